/* rtl/core/swrc_pkg.sv */
// types and constants for the scanline widest run center block
// no dependencies

package swrc_pkg;

  typedef enum logic [1:0] {
    CLASS_BLACK   = 2'd0,
    CLASS_WHITE   = 2'd1,
    CLASS_NEITHER = 2'd2,
    CLASS_UNIFORM = 2'd3
  } row_class_t;

  typedef enum logic [1:0] {
    REG_ROW_WIDTH      = 2'd0,
    REG_UNIFORM_MARGIN = 2'd1,
    REG_RATIO_LIMIT    = 2'd2
  } reg_index_t;

  localparam int COUNT_W = 11;
  localparam int OUT_W   = 10;
  localparam int RATIO_W = 6;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX        = 11'd2047;
  localparam logic [10:0]        ROW_WIDTH_RESET  = 11'd640;
  localparam logic [9:0]         MARGIN_RESET     = 10'd10;
  localparam logic [5:0]         RATIO_RESET      = 6'd10;

endpackage

/* rtl/core/scanline_widest_run_center.sv */
// scanline widest run center: pixel tracking, row snapshot, row classification
// depends on swrc_pkg

// Takes one thresholded pixel per transaction and returns one result per row,
// on the transaction that carries row_end. A pixel is accepted every cycle
// while in_stall is low; its run tracking is a few compares on the column
// counter. The row's final counts and best runs go into a snapshot register,
// and the classification (distance compares and two small ratio multiplies)
// fills the output register once that register is free or being taken.
// in_stall rises only when a snapshot waits behind a stalled output. The user
// must write configuration through the APB port while the block is idle; the block does not enforce it.
module scanline_widest_run_center #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swrc_pkg::ADDR_W-1:0]  paddr,
  input  logic [swrc_pkg::DATA_W-1:0]  pwdata,
  output logic [swrc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         pixel_white,
  input  logic                         row_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   row_class,
  output logic                         run_found,
  output logic [swrc_pkg::OUT_W-1:0]   run_center,
  output logic [swrc_pkg::OUT_W-1:0]   run_span
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int PW = swrc_pkg::COUNT_W + swrc_pkg::RATIO_W + 1;

  // configuration
  logic [10:0]                   row_width;
  logic [9:0]                    uniform_margin;
  logic [swrc_pkg::RATIO_W-1:0]  ratio_limit;
  logic                          cfg_write;
  swrc_pkg::reg_index_t          cfg_sel;

  assign pready    = 1'b1;
  assign cfg_sel   = swrc_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width      <= swrc_pkg::ROW_WIDTH_RESET;
      uniform_margin <= swrc_pkg::MARGIN_RESET;
      ratio_limit    <= swrc_pkg::RATIO_RESET;
    end else if (cfg_write) begin
      case (cfg_sel)
        swrc_pkg::REG_ROW_WIDTH:      row_width      <= pwdata[10:0];
        swrc_pkg::REG_UNIFORM_MARGIN: uniform_margin <= pwdata[9:0];
        swrc_pkg::REG_RATIO_LIMIT:    ratio_limit    <= pwdata[swrc_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      swrc_pkg::REG_ROW_WIDTH:      prdata = swrc_pkg::DATA_W'(row_width);
      swrc_pkg::REG_UNIFORM_MARGIN: prdata = swrc_pkg::DATA_W'(uniform_margin);
      swrc_pkg::REG_RATIO_LIMIT:    prdata = swrc_pkg::DATA_W'(ratio_limit);
      default:                      prdata = '0;
    endcase
  end

  // pipeline control
  logic snap_valid;
  logic out_load;
  logic accept;

  assign out_load = snap_valid && (!out_valid || !out_stall);
  assign in_stall = snap_valid && !out_load;
  assign accept   = in_valid && !in_stall;

  // row state
  logic [CW-1:0]                 column;
  logic [swrc_pkg::COUNT_W-1:0]  white_count;
  logic [swrc_pkg::COUNT_W-1:0]  black_count;
  logic                          prev_pixel;
  logic [CW-1:0]                 run_start;
  logic [CW-1:0]                 best_white_min;
  logic [CW-1:0]                 best_white_span;
  logic [CW-1:0]                 best_black_min;
  logic [CW-1:0]                 best_black_span;

  logic [swrc_pkg::COUNT_W-1:0]  white_count_next;
  logic [swrc_pkg::COUNT_W-1:0]  black_count_next;
  logic [CW-1:0]                 run_start_next;
  logic [CW-1:0]                 best_white_min_next;
  logic [CW-1:0]                 best_white_span_next;
  logic [CW-1:0]                 best_black_min_next;
  logic [CW-1:0]                 best_black_span_next;
  logic [LW-1:0]                 limit;
  logic                          in_window;
  logic                          run_cont;
  logic [CW-1:0]                 cur_span;

  always_comb begin
    limit = (LW'(row_width) > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : LW'(row_width);
    in_window = (column >= CW'(2)) && (LW'(column) + LW'(2) <= limit);
    run_cont  = (column >= CW'(3)) && (pixel_white == prev_pixel);

    white_count_next = white_count;
    black_count_next = black_count;
    if (pixel_white) begin
      if (white_count < swrc_pkg::COUNT_MAX) white_count_next = white_count + 1'b1;
    end else begin
      if (black_count < swrc_pkg::COUNT_MAX) black_count_next = black_count + 1'b1;
    end

    run_start_next       = run_start;
    best_white_min_next  = best_white_min;
    best_white_span_next = best_white_span;
    best_black_min_next  = best_black_min;
    best_black_span_next = best_black_span;
    cur_span             = column - run_start_next;
    if (in_window) begin
      if (!run_cont) run_start_next = column;
      cur_span = column - run_start_next;
      if (pixel_white) begin
        if (cur_span > best_white_span) begin
          best_white_span_next = cur_span;
          best_white_min_next  = run_start_next;
        end
      end else begin
        if (cur_span > best_black_span) begin
          best_black_span_next = cur_span;
          best_black_min_next  = run_start_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && row_end)) begin
      column          <= '0;
      white_count     <= swrc_pkg::COUNT_W'(1);
      black_count     <= swrc_pkg::COUNT_W'(1);
      prev_pixel      <= 1'b0;
      run_start       <= '0;
      best_white_min  <= '0;
      best_white_span <= '0;
      best_black_min  <= '0;
      best_black_span <= '0;
    end else if (accept) begin
      if (column < CW'(MAX_WIDTH - 1)) column <= column + 1'b1;
      white_count     <= white_count_next;
      black_count     <= black_count_next;
      prev_pixel      <= pixel_white;
      run_start       <= run_start_next;
      best_white_min  <= best_white_min_next;
      best_white_span <= best_white_span_next;
      best_black_min  <= best_black_min_next;
      best_black_span <= best_black_span_next;
    end
  end

  // row snapshot
  logic [swrc_pkg::COUNT_W-1:0]  snap_white;
  logic [swrc_pkg::COUNT_W-1:0]  snap_black;
  logic [CW-1:0]                 snap_white_min;
  logic [CW-1:0]                 snap_white_span;
  logic [CW-1:0]                 snap_black_min;
  logic [CW-1:0]                 snap_black_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && row_end) begin
      snap_valid <= 1'b1;
    end else if (out_load) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && row_end) begin
      snap_white      <= white_count_next;
      snap_black      <= black_count_next;
      snap_white_min  <= best_white_min_next;
      snap_white_span <= best_white_span_next;
      snap_black_min  <= best_black_min_next;
      snap_black_span <= best_black_span_next;
    end
  end

  // classification
  logic [swrc_pkg::COUNT_W-1:0]  dist_white;
  logic [swrc_pkg::COUNT_W-1:0]  dist_black;
  logic [PW-1:0]                 white_bound;
  logic [PW-1:0]                 black_bound;
  logic [PW-1:0]                 ratio_plus;
  logic                          is_uniform;
  logic                          white_dom;
  logic                          black_dom;
  swrc_pkg::row_class_t          class_next;
  logic                          found_next;
  logic [CW-1:0]                 sel_min;
  logic [CW-1:0]                 sel_span;
  logic [CW:0]                   end_sum;

  always_comb begin
    dist_white = (snap_white > row_width) ? snap_white - row_width : row_width - snap_white;
    dist_black = (snap_black > row_width) ? snap_black - row_width : row_width - snap_black;
    is_uniform = (dist_white < swrc_pkg::COUNT_W'(uniform_margin)) ||
                 (dist_black < swrc_pkg::COUNT_W'(uniform_margin));
    ratio_plus  = PW'(ratio_limit) + PW'(1);
    white_bound = ratio_plus * PW'(snap_black);
    black_bound = ratio_plus * PW'(snap_white);
    white_dom   = (snap_white > snap_black) && (PW'(snap_white) < white_bound);
    black_dom   = (snap_black > snap_white) && (PW'(snap_black) < black_bound);

    priority if (is_uniform) class_next = swrc_pkg::CLASS_UNIFORM;
    else if (white_dom)      class_next = swrc_pkg::CLASS_WHITE;
    else if (black_dom)      class_next = swrc_pkg::CLASS_BLACK;
    else                     class_next = swrc_pkg::CLASS_NEITHER;

    sel_min    = '0;
    sel_span   = '0;
    found_next = 1'b0;
    if (class_next == swrc_pkg::CLASS_BLACK && snap_white_span != '0) begin
      found_next = 1'b1;
      sel_min    = snap_white_min;
      sel_span   = snap_white_span;
    end else if (class_next == swrc_pkg::CLASS_WHITE && snap_black_span != '0) begin
      found_next = 1'b1;
      sel_min    = snap_black_min;
      sel_span   = snap_black_span;
    end
    end_sum = (CW + 1)'(sel_min) + (CW + 1)'(sel_min) + (CW + 1)'(sel_span);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row_class  <= class_next;
      run_found  <= found_next;
      run_center <= swrc_pkg::OUT_W'(end_sum[CW:1]);
      run_span   <= swrc_pkg::OUT_W'(sel_span);
    end
  end

  // checks
  a_stall_needs_snap: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> snap_valid && out_valid && out_stall)
    else $error("input stalled without a blocked snapshot");

  a_row_end_snap: assert property (@(posedge clk) disable iff (rst)
    accept && row_end |=> snap_valid)
    else $error("row end transaction did not fill the snapshot");

  a_row_end_clear: assert property (@(posedge clk) disable iff (rst)
    accept && row_end |=> column == '0 && white_count == swrc_pkg::COUNT_W'(1))
    else $error("row state not cleared after row end");

  a_no_run_unclassed: assert property (@(posedge clk) disable iff (rst)
    out_valid && (row_class == swrc_pkg::CLASS_NEITHER || row_class == swrc_pkg::CLASS_UNIFORM)
    |-> !run_found && run_span == '0 && run_center == '0)
    else $error("run reported for a row without a dominant color");

endmodule

/* test/scanline_widest_run_center_checker.sv */
// checker for the scanline widest run center block: tracks register writes and
// accepted pixels, predicts one result per row and compares each output transaction
// depends on swrc_pkg
`timescale 1ns / 100ps

module scanline_widest_run_center_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swrc_pkg::ADDR_W-1:0]   paddr,
  input  logic [swrc_pkg::DATA_W-1:0]   pwdata,
  input  logic [swrc_pkg::DATA_W-1:0]   prdata,
  input  logic                          pready,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          pixel_white,
  input  logic                          row_end,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [1:0]                    row_class,
  input  logic                          run_found,
  input  logic [swrc_pkg::OUT_W-1:0]    run_center,
  input  logic [swrc_pkg::OUT_W-1:0]    run_span,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    swrc_pkg::row_class_t       cls;
    logic                       found;
    logic [swrc_pkg::OUT_W-1:0] center;
    logic [swrc_pkg::OUT_W-1:0] span;
  } row_result_t;

  row_result_t rows_due[$];

  logic [10:0]                  row_width_q;
  logic [9:0]                   margin_q;
  logic [swrc_pkg::RATIO_W-1:0] ratio_q;
  logic [swrc_pkg::OUT_W-1:0]   column_q;
  logic [swrc_pkg::OUT_W-1:0]   run_begin_q;
  logic [swrc_pkg::COUNT_W-1:0] white_cnt;
  logic [swrc_pkg::COUNT_W-1:0] black_cnt;
  logic                         prev_pix;
  logic [swrc_pkg::OUT_W-1:0]   white_min;
  logic [swrc_pkg::OUT_W-1:0]   white_span;
  logic [swrc_pkg::OUT_W-1:0]   black_min;
  logic [swrc_pkg::OUT_W-1:0]   black_span;

  task automatic report_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void clear_row();
    column_q    = '0;
    white_cnt   = swrc_pkg::COUNT_W'(1);
    black_cnt   = swrc_pkg::COUNT_W'(1);
    prev_pix    = 1'b0;
    run_begin_q = '0;
    white_min   = '0;
    white_span  = '0;
    black_min   = '0;
    black_span  = '0;
  endfunction

  // advances the row state by one pixel; returns 1 with the row result on row end
  function automatic bit advance_scanline(input logic pix, input logic last,
                                          output row_result_t res);
    int lim;
    int c;
    int w;
    int b;
    int wd;
    int dw;
    int db;
    lim = (row_width_q > MAX_WIDTH) ? MAX_WIDTH : int'(row_width_q);
    c   = int'(column_q);
    res = '0;
    if (pix) begin
      if (white_cnt != swrc_pkg::COUNT_MAX) white_cnt++;
    end else begin
      if (black_cnt != swrc_pkg::COUNT_MAX) black_cnt++;
    end
    if (c >= 2 && c <= lim - 2) begin
      if (!(c >= 3 && pix == prev_pix)) run_begin_q = column_q;
      if (pix && (column_q - run_begin_q) > white_span) begin
        white_span = column_q - run_begin_q;
        white_min  = run_begin_q;
      end
      if (!pix && (column_q - run_begin_q) > black_span) begin
        black_span = column_q - run_begin_q;
        black_min  = run_begin_q;
      end
    end
    prev_pix = pix;
    if (!last) begin
      if (c < MAX_WIDTH - 1) column_q++;
      return 1'b0;
    end

    w  = int'(white_cnt);
    b  = int'(black_cnt);
    wd = int'(row_width_q);
    dw = (w > wd) ? w - wd : wd - w;
    db = (b > wd) ? b - wd : wd - b;
    if (dw < int'(margin_q) || db < int'(margin_q)) res.cls = swrc_pkg::CLASS_UNIFORM;
    else if (w > b && w / b <= int'(ratio_q)) res.cls = swrc_pkg::CLASS_WHITE;
    else if (b > w && b / w <= int'(ratio_q)) res.cls = swrc_pkg::CLASS_BLACK;
    else res.cls = swrc_pkg::CLASS_NEITHER;

    if (res.cls == swrc_pkg::CLASS_BLACK && white_span != 0) begin
      res.found  = 1'b1;
      res.span   = white_span;
      res.center = swrc_pkg::OUT_W'((2 * int'(white_min) + int'(white_span)) >> 1);
    end else if (res.cls == swrc_pkg::CLASS_WHITE && black_span != 0) begin
      res.found  = 1'b1;
      res.span   = black_span;
      res.center = swrc_pkg::OUT_W'((2 * int'(black_min) + int'(black_span)) >> 1);
    end
    clear_row();
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    row_result_t want;
    logic [swrc_pkg::DATA_W-1:0] reg_val;
    if (rst) begin
      row_width_q = swrc_pkg::ROW_WIDTH_RESET;
      margin_q    = swrc_pkg::MARGIN_RESET;
      ratio_q     = swrc_pkg::RATIO_RESET;
      clear_row();
      rows_due.delete();
    end else begin
      if (psel && penable && pready) begin
        case (swrc_pkg::reg_index_t'(paddr[swrc_pkg::ADDR_W-1:2]))
          swrc_pkg::REG_ROW_WIDTH:      reg_val = swrc_pkg::DATA_W'(row_width_q);
          swrc_pkg::REG_UNIFORM_MARGIN: reg_val = swrc_pkg::DATA_W'(margin_q);
          swrc_pkg::REG_RATIO_LIMIT:    reg_val = swrc_pkg::DATA_W'(ratio_q);
          default:                      reg_val = prdata;
        endcase
        if (pwrite) begin
          case (swrc_pkg::reg_index_t'(paddr[swrc_pkg::ADDR_W-1:2]))
            swrc_pkg::REG_ROW_WIDTH:      row_width_q = pwdata[10:0];
            swrc_pkg::REG_UNIFORM_MARGIN: margin_q    = pwdata[9:0];
            swrc_pkg::REG_RATIO_LIMIT:    ratio_q     = pwdata[swrc_pkg::RATIO_W-1:0];
            default: ;
          endcase
        end else if (prdata !== reg_val) begin
          report_error($sformatf("register read at %0d: got %0d, expected %0d",
                                 paddr, prdata, reg_val));
        end
      end

      if (out_valid && !out_stall) begin
        if (rows_due.size() == 0) begin
          report_error("result transaction with no row pending");
        end else begin
          want = rows_due.pop_front();
          if (row_class !== want.cls)
            report_error($sformatf("row_class got %0d, expected %0d", row_class, want.cls));
          if (run_found !== want.found)
            report_error($sformatf("run_found got %0d, expected %0d", run_found, want.found));
          if (run_center !== want.center)
            report_error($sformatf("run_center got %0d, expected %0d", run_center, want.center));
          if (run_span !== want.span)
            report_error($sformatf("run_span got %0d, expected %0d", run_span, want.span));
        end
      end

      if (in_valid && !in_stall && advance_scanline(pixel_white, row_end, want))
        rows_due.push_back(want);
    end
    pending = rows_due.size();
  end

endmodule

/* test/scanline_widest_run_center_tb.sv */
// testbench top for the scanline widest run center block: clock, reset,
// register setup, pixel and stall stimulus, watchdog and verdict
// depends on swrc_pkg, scanline_widest_run_center and its checker
`timescale 1ns / 100ps

module scanline_widest_run_center_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [swrc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [swrc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [swrc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          pixel_white = 1'b0;
  logic                          row_end = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [1:0]                    row_class;
  logic                          run_found;
  logic [swrc_pkg::OUT_W-1:0]    run_center;
  logic [swrc_pkg::OUT_W-1:0]    run_span;
  int                            fail_count;
  int                            pending;

  int send_idle;
  int recv_idle;
  int hold_asked;
  int hold_served;
  int hold_left;
  int quiet_cycles;

  always #1 clk = ~clk;

  scanline_widest_run_center i_dut (.*);

  scanline_widest_run_center_checker i_checker (.*);

  always @(negedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic pix, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    pixel_white <= pix;
    row_end     <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_bits(input string shape);
    for (int i = 0; i < shape.len(); i++)
      send_pixel(shape[i] == "1", i == shape.len() - 1);
  endtask

  task automatic send_row(input int len, input int white_pct, input int max_run);
    int left;
    int run;
    logic pix;
    left = len;
    while (left > 0) begin
      pix = ($urandom_range(99) < white_pct);
      run = $urandom_range(1, max_run);
      if (run > left) run = left;
      repeat (run) begin
        left--;
        send_pixel(pix, left == 0);
      end
    end
  endtask

  task automatic apb_access(input logic wr, input swrc_pkg::reg_index_t idx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= swrc_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= swrc_pkg::DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  // registers change only with no row in flight
  task automatic set_config(input int width, input int margin, input int ratio);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    apb_access(1'b1, swrc_pkg::REG_ROW_WIDTH, width);
    apb_access(1'b1, swrc_pkg::REG_UNIFORM_MARGIN, margin);
    apb_access(1'b1, swrc_pkg::REG_RATIO_LIMIT, ratio);
    apb_access(1'b0, swrc_pkg::REG_ROW_WIDTH, 0);
    apb_access(1'b0, swrc_pkg::REG_UNIFORM_MARGIN, 0);
    apb_access(1'b0, swrc_pkg::REG_RATIO_LIMIT, 0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input int width, input int margin, input int ratio,
                           input int min_len, input int max_len, input int items);
    int sent;
    int len;
    set_config(width, margin, ratio);
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(min_len, max_len);
      send_row(len, $urandom_range(0, 100), $urandom_range(1, 8));
      sent += len;
    end
  endtask

  initial begin
    send_idle = 14;
    recv_idle = 45;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: single pixel rows, lone runs, equal width runs
    send_bits("1");
    send_bits("0");
    send_bits("0011000");
    send_bits("11100111");
    send_bits("0011011");
    send_bits("1110011100111");

    run_phase(16, 2, 3, 4, 20, 60);
    run_phase(8, 0, 1, 2, 12, 60);
    run_phase(3, 0, 63, 1, 8, 30);
    run_phase(0, 1023, 0, 1, 8, 20);

    send_idle = 45;
    recv_idle = 14;
    run_phase(40, 5, 10, 10, 48, 60);
    run_phase(24, 0, 0, 4, 30, 40);
    run_phase(2047, 1023, 0, 10, 40, 40);
    run_phase(1030, 0, 2, 10, 40, 40);

    send_idle = 0;
    recv_idle = 0;
    run_phase(24, 3, 2, 6, 30, 60);
    set_config(12, 0, 4);
    hold_asked++;
    repeat (30) send_row($urandom_range(1, 3), 50, 2);
    run_phase(16, 1, 5, 4, 20, 40);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
